FILE: rtl/core/bnd_pkg.sv
`default_nettype none

package bnd_pkg;

  typedef enum logic [3:0] {
    ST_HUNT1   = 4'd0,
    ST_HUNT2   = 4'd1,
    ST_CLASS   = 4'd2,
    ST_ID      = 4'd3,
    ST_LEN_LO  = 4'd4,
    ST_LEN_HI  = 4'd5,
    ST_PAYLOAD = 4'd6,
    ST_CK_A    = 4'd7,
    ST_CK_B    = 4'd8
  } parse_t;

  typedef enum logic [1:0] {
    FS_NONE     = 2'd0,
    FS_GOOD     = 2'd1,
    FS_BAD_CK   = 2'd2,
    FS_OVERLONG = 2'd3
  } frame_status_t;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_SECOND = 8'd1;

  localparam logic [7:0] PREAMBLE_FIRST_RST  = 8'hB5;
  localparam logic [7:0] PREAMBLE_SECOND_RST = 8'h62;

  localparam logic [9:0] FRAME_LENGTH_SAT = 10'd1023;

  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

endpackage

`default_nettype wire

FILE: rtl/core/binary_nav_frame_deframer.sv
// Binary navigation frame deframer.
// s_* channel: one received byte per transaction in s_tdata.
// m_* channel: one result per accepted byte. m_tuser carries the payload
//   strobe and the frame status; m_tdata carries payload index, payload
//   byte, message id and frame length. Fields that do not apply read 0.
// cfg_* channel: writes the two preamble bytes (index 0 and 1); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// The result for a byte is registered and appears on m_* in the cycle after
//   the byte is accepted. Throughput: one byte per cycle while m_tready is
//   high, set by the single output register stage.
// When the receiver stalls, the pending result holds on m_*; s_tready stays
//   high as long as the output register is empty or being emptied, so a
//   stall backs up to the sender after one held result.
// Reset: synchronous, clears the parser to preamble hunt, clears sums and
//   the output valid, and loads the preamble bytes 0xB5 and 0x62.
// MAX_PAYLOAD: largest accepted payload length; longer frames are reported
//   overlong on the high length byte.
`default_nettype none

module binary_nav_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,  // rx_byte
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // payload_index[8:0], payload_byte[16:9], message_id[24:17],
  // frame_length[34:25], zero pad[39:35]
  output logic [bnd_pkg::OUT_DATA_W-1:0]           m_tdata,
  // payload_strobe[0], frame_status[2:1]
  output logic [bnd_pkg::OUT_USER_W-1:0]           m_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bnd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [7:0]                          cfg_data
);
  import bnd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  logic [7:0]       preamble_first;
  logic [7:0]       preamble_second;
  parse_t           state;
  parse_t           state_next;
  logic [7:0]       sum_a;
  logic [7:0]       sum_a_next;
  logic [7:0]       sum_b;
  logic [7:0]       sum_b_next;
  logic [7:0]       held_id;
  logic [7:0]       held_id_next;
  logic [15:0]      length_word;
  logic [15:0]      length_word_next;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;

  logic             in_fire;
  logic [7:0]       d;
  logic [7:0]       sa_add;
  logic [7:0]       sb_add;
  logic [CNT_W:0]   count_inc;

  logic             strobe;
  logic [8:0]       idx;
  logic [7:0]       pbyte;
  frame_status_t    status;
  logic [7:0]       rep_id;
  logic [9:0]       rep_len;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign d         = s_tdata;
  assign sa_add    = sum_a + d;
  assign sb_add    = sum_b + sa_add;
  assign count_inc = {1'b0, byte_count} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_first  <= PREAMBLE_FIRST_RST;
      preamble_second <= PREAMBLE_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PREAMBLE_FIRST:  preamble_first  <= cfg_data;
        CFG_PREAMBLE_SECOND: preamble_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next       = state;
    sum_a_next       = sum_a;
    sum_b_next       = sum_b;
    held_id_next     = held_id;
    length_word_next = length_word;
    byte_count_next  = byte_count;
    strobe           = 1'b0;
    idx              = '0;
    pbyte            = '0;
    status           = FS_NONE;
    case (state)
      ST_HUNT1: begin
        state_next = (d == preamble_first) ? ST_HUNT2 : ST_HUNT1;
      end
      ST_HUNT2: begin
        if (d == preamble_second) begin
          state_next = ST_CLASS;
        end else begin
          state_next = (d == preamble_first) ? ST_HUNT2 : ST_HUNT1;
        end
      end
      ST_CLASS: begin
        sum_a_next = d;
        sum_b_next = d;
        state_next = ST_ID;
      end
      ST_ID: begin
        sum_a_next   = sa_add;
        sum_b_next   = sb_add;
        held_id_next = d;
        state_next   = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        sum_a_next       = sa_add;
        sum_b_next       = sb_add;
        length_word_next = {8'h00, d};
        state_next       = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        sum_a_next       = sa_add;
        sum_b_next       = sb_add;
        length_word_next = {d, length_word[7:0]};
        byte_count_next  = '0;
        if ({d, length_word[7:0]} > MAX_LEN) begin
          status     = FS_OVERLONG;
          state_next = ST_HUNT1;
        end else begin
          state_next = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        sum_a_next      = sa_add;
        sum_b_next      = sb_add;
        strobe          = 1'b1;
        idx             = 9'(byte_count);
        pbyte           = d;
        byte_count_next = count_inc[CNT_W-1:0];
        state_next      = (16'(count_inc) < length_word) ? ST_PAYLOAD : ST_CK_A;
      end
      ST_CK_A: begin
        if (d != sum_a) begin
          status     = FS_BAD_CK;
          state_next = ST_HUNT1;
        end else begin
          state_next = ST_CK_B;
        end
      end
      ST_CK_B: begin
        status     = (d == sum_b) ? FS_GOOD : FS_BAD_CK;
        state_next = ST_HUNT1;
      end
      default: begin
        state_next = ST_HUNT1;
      end
    endcase
  end

  // report fields follow the values this byte leaves behind
  always_comb begin
    rep_id  = '0;
    rep_len = '0;
    if (status != FS_NONE) begin
      rep_id  = held_id_next;
      rep_len = (length_word_next > 16'(FRAME_LENGTH_SAT)) ? FRAME_LENGTH_SAT
                                                            : length_word_next[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HUNT1;
      sum_a       <= '0;
      sum_b       <= '0;
      held_id     <= '0;
      length_word <= '0;
      byte_count  <= '0;
    end else if (in_fire) begin
      state       <= state_next;
      sum_a       <= sum_a_next;
      sum_b       <= sum_b_next;
      held_id     <= held_id_next;
      length_word <= length_word_next;
      byte_count  <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {5'b00000, rep_len, rep_id, pbyte, idx};
      m_tuser <= {status, strobe};
    end
  end

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held result");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_tvalid)
    else $error("accepted byte produced no result");

  a_ck_b_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (in_fire && state == ST_CK_B) |=> state == ST_HUNT1)
    else $error("frame did not end after second checksum byte");

  a_payload_len_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAYLOAD |-> (length_word <= MAX_LEN &&
      (16'(byte_count) < length_word || byte_count == '0)))
    else $error("payload count out of range");

  a_strobe_no_status: assert property (@(posedge clk) disable iff (rst)
    (in_fire && strobe) |=> (m_tuser[2:1] == FS_NONE))
    else $error("payload byte carried a frame status");

endmodule

`default_nettype wire
